@@ sv/gsg_pkg.sv @@
// Shared types, constants and GF(2) helper functions for the Gold sequence generator.
// No dependencies; used by gsg_seed, gsg_core and gold_sequence_generator.
`default_nettype none

package gsg_pkg;

    // Register width of both linear feedback registers.
    localparam int WORD_W = 31;
    // Steps in one output byte and the width of the request count.
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    // Width of the restart offset.
    localparam int OFFSET_W = 16;

    typedef logic [WORD_W-1:0]              t_word;
    // A GF(2) matrix kept as columns: entry j is the image of unit vector j.
    typedef logic [WORD_W-1:0][WORD_W-1:0]  t_mat;
    typedef logic [BYTE_W-1:0]              t_byte;
    typedef logic [COUNT_W-1:0]             t_count;

    // Feedback taps: x(n+3)+x(n) and x(n+3)+x(n+2)+x(n+1)+x(n).
    localparam t_word TAPS_FIRST  = 31'h0000_0009;
    localparam t_word TAPS_SECOND = 31'h0000_000F;
    // Start value of the first register on a restart.
    localparam t_word FIRST_START = 31'h0000_0001;
    // Largest number of steps taken in one request.
    localparam t_count MAX_STEPS = COUNT_W'(BYTE_W);

    // Seed values loaded into both registers on a restart.
    typedef struct packed {
        t_word first;
        t_word second;
    } t_seeds;

    // One register step: shift right, feedback enters at the top bit.
    function automatic t_word lfsr_step(t_word s, t_word taps);
        return {^(s & taps), s[WORD_W-1:1]};
    endfunction

    // Matrix times vector over GF(2).
    function automatic t_word mat_vec_mul(t_mat m, t_word v);
        t_word acc;
        acc = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (v[j]) begin
                acc = acc ^ m[j];
            end
        end
        return acc;
    endfunction

    // Product a * b: apply b first, then a.
    function automatic t_mat mat_mul(t_mat a, t_mat b);
        t_mat p;
        for (int j = 0; j < WORD_W; j++) begin
            p[j] = mat_vec_mul(a, b[j]);
        end
        return p;
    endfunction

    // Matrix of count register steps, built by square and multiply.
    function automatic t_mat mat_pow(t_word taps, logic [OFFSET_W-1:0] count);
        t_mat r;
        t_mat p;
        for (int j = 0; j < WORD_W; j++) begin
            r[j] = t_word'(1) << j;
            p[j] = lfsr_step(t_word'(1) << j, taps);
        end
        for (int k = 0; k < OFFSET_W; k++) begin
            if (count[k]) begin
                r = mat_mul(p, r);
            end
            p = mat_mul(p, p);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/gsg_seed.sv @@
// Configuration register: stores c_init already advanced by the restart offset.
// Depends on gsg_pkg for the matrix functions and the seed struct.
`default_nettype none

module gsg_seed #(
    parameter int INIT_OFFSET = 1600
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_fire,
    input  gsg_pkg::t_word   i_cfg_data,
    output gsg_pkg::t_seeds  o_seeds
);
    import gsg_pkg::*;

    // Offset matrices, worked out at elaboration.
    localparam t_mat MAT_FIRST  = mat_pow(TAPS_FIRST, OFFSET_W'(INIT_OFFSET));
    localparam t_mat MAT_SECOND = mat_pow(TAPS_SECOND, OFFSET_W'(INIT_OFFSET));
    localparam t_word SEED_FIRST = mat_vec_mul(MAT_FIRST, FIRST_START);

    t_word r_seed_second;

    // Advance the written value by the offset at the time of the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_second <= '0;
        end else if (i_cfg_fire) begin
            r_seed_second <= mat_vec_mul(MAT_SECOND, i_cfg_data);
        end
    end

    assign o_seeds.first  = SEED_FIRST;
    assign o_seeds.second = r_seed_second;

endmodule

`default_nettype wire

@@ sv/gsg_core.sv @@
// Sequence core: the two feedback registers and the logic that emits one byte per request.
// Depends on gsg_pkg for the step function, types and constants.
`default_nettype none

module gsg_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_fire,
    input  wire              i_restart,
    input  gsg_pkg::t_count  i_valid_bits,
    input  gsg_pkg::t_seeds  i_seeds,
    output gsg_pkg::t_byte   o_data_byte
);
    import gsg_pkg::*;

    t_word r_first;
    t_word r_second;
    t_word n_first;
    t_word n_second;

    t_count w_steps;
    t_word  w_first  [BYTE_W+1];
    t_word  w_second [BYTE_W+1];
    t_byte  w_byte;

    // Clamp the request to one byte.
    assign w_steps = (i_valid_bits > MAX_STEPS) ? MAX_STEPS : i_valid_bits;

    // Walk up to eight steps; each step is one shift and a few XORs.
    always_comb begin
        w_first[0]  = i_restart ? i_seeds.first  : r_first;
        w_second[0] = i_restart ? i_seeds.second : r_second;
        for (int k = 0; k < BYTE_W; k++) begin
            w_first[k+1]  = lfsr_step(w_first[k], TAPS_FIRST);
            w_second[k+1] = lfsr_step(w_second[k], TAPS_SECOND);
            w_byte[k] = (COUNT_W'(k) < w_steps) & (w_first[k][0] ^ w_second[k][0]);
        end
        n_first  = w_first[w_steps];
        n_second = w_second[w_steps];
    end

    // The registers move on only when the request is passed to the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= '0;
        end else if (i_fire) begin
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_data_byte = w_byte;

endmodule

`default_nettype wire

@@ sv/gold_sequence_generator.sv @@
// Top level of the Gold sequence generator with two 31-bit registers: handshakes, input and result registers.
// Depends on gsg_pkg, gsg_seed and gsg_core.
//
//   Channel  | Signals                                   | Direction
//   ---------+-------------------------------------------+----------
//   request  | i_in_valid, o_in_ready, i_restart,        | in
//            | i_valid_bits                              |
//   result   | o_out_valid, i_out_ready, o_data_byte     | out
//   config   | i_cfg_valid, o_cfg_ready, i_cfg_data      | in
//
// One request per cycle is sustained while i_out_ready stays high; a request passes the input
// register and then the result register, where its byte is offered until it is taken.
// The walk of up to eight register steps sits between the input and result registers.
// A restart only selects stored seeds: the offset is applied when c_init is written.
// Synchronous active-low reset clears both feedback registers and the handshake state.
// While the result is stalled, one more request is held in the input register.
`default_nettype none

module gold_sequence_generator #(
    parameter int INIT_OFFSET = 1600
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire              i_restart,
    input  gsg_pkg::t_count  i_valid_bits,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output gsg_pkg::t_byte   o_data_byte,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  gsg_pkg::t_word   i_cfg_data
);
    import gsg_pkg::*;

    logic   r_in_valid;
    logic   r_in_restart;
    t_count r_in_bits;
    logic   r_out_valid;
    t_byte  r_data_byte;

    logic   w_fire;
    t_byte  w_byte;
    t_seeds w_seeds;

    // The held request moves on when the result register is free or being emptied.
    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_cfg_ready = 1'b1;

    gsg_seed #(
        .INIT_OFFSET(INIT_OFFSET)
    ) u_seed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_fire (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_seeds    (w_seeds)
    );

    gsg_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_restart    (r_in_restart),
        .i_valid_bits (r_in_bits),
        .i_seeds      (w_seeds),
        .o_data_byte  (w_byte)
    );

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_restart <= i_restart;
            r_in_bits    <= i_valid_bits;
        end
    end

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_data_byte <= w_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data_byte;

endmodule

`default_nettype wire
